// ===== design/ia_pkg.sv =====
// Shared types, codes and helper functions of the integer interval unit.
`default_nettype none
package ia_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int IN_WIDTH = 32;
	localparam int WIDE = 34;

	typedef enum logic [2:0] {
		KIND_ADD      = 3'd0,
		KIND_MUL      = 3'd1,
		KIND_DIV      = 3'd2,
		KIND_MERGE    = 3'd3,
		KIND_NARROW_T = 3'd4,
		KIND_NARROW_F = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		CC_EQ = 3'd0,
		CC_NE = 3'd1,
		CC_LT = 3'd2,
		CC_LE = 3'd3,
		CC_GT = 3'd4,
		CC_GE = 3'd5
	} cc_t;

	typedef struct packed {
		logic               ok;
		logic signed [WIDE-1:0] lo;
		logic signed [WIDE-1:0] hi;
	} nv_t;

	typedef struct packed {
		kind_t kind;
		logic  ab_ok;
		logic  bz;
		logic  strad;
		logic  s_ok;
		logic  at;
		logic  af;
	} ctl_t;

	function automatic logic signed [WIDE-1:0] minv(input int w);
		minv = -(WIDE'(1) <<< (w - 1));
	endfunction

	function automatic logic signed [WIDE-1:0] maxv(input int w);
		maxv = (WIDE'(1) <<< (w - 1)) - WIDE'(1);
	endfunction

	function automatic nv_t raise_low(input nv_t r, input logic signed [WIDE-1:0] v);
		nv_t o;
		o.ok = r.ok && (r.hi >= v);
		o.lo = (v > r.lo) ? v : r.lo;
		o.hi = r.hi;
		raise_low = o;
	endfunction

	function automatic nv_t drop_high(input nv_t r, input logic signed [WIDE-1:0] v);
		nv_t o;
		o.ok = r.ok && (r.lo <= v);
		o.lo = r.lo;
		o.hi = (v < r.hi) ? v : r.hi;
		drop_high = o;
	endfunction

endpackage
`default_nettype wire

// ===== design/ia_req_if.sv =====
// Request channel: one operation item.
`default_nettype none
interface ia_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic signed [31:0] a_lo;
	logic signed [31:0] a_hi;
	logic signed [31:0] b_lo;
	logic signed [31:0] b_hi;
	logic [2:0]  cond_code;
	logic signed [31:0] const_value;

	modport source (output valid, kind, a_lo, a_hi, b_lo, b_hi, cond_code, const_value,
		input ready);
	modport sink (input valid, kind, a_lo, a_hi, b_lo, b_hi, cond_code, const_value,
		output ready);
endinterface
`default_nettype wire

// ===== design/ia_rsp_if.sv =====
// Response channel: one result interval item.
`default_nettype none
interface ia_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] res_lo;
	logic signed [31:0] res_hi;
	logic        res_valid;
	logic        always_true;
	logic        always_false;

	modport source (output valid, res_lo, res_hi, res_valid, always_true, always_false,
		input ready);
	modport sink (input valid, res_lo, res_hi, res_valid, always_true, always_false,
		output ready);
endinterface
`default_nettype wire

// ===== design/int_interval_alu.sv =====
// Top level of the signed integer interval arithmetic unit.
// Throughput: one item per cycle unless the output stalls; the divider pipeline,
// one quotient bit per stage, sets the depth of the whole pipeline.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module int_interval_alu #(
	parameter int VALUE_WIDTH = ia_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ia_req_if.sink    req,
	ia_rsp_if.source  rsp
);
	localparam int W = VALUE_WIDTH;
	localparam int DIV_LAT = W + 2;
	localparam logic signed [ia_pkg::WIDE-1:0] MINV = ia_pkg::minv(W);
	localparam logic signed [ia_pkg::WIDE-1:0] MAXV = ia_pkg::maxv(W);
	localparam logic signed [2*W-1:0] MINV_P = (2*W)'(MINV);
	localparam logic signed [2*W-1:0] MAXV_P = (2*W)'(MAXV);
	localparam logic signed [W:0] MINV_D = (W+1)'(MINV);
	localparam logic signed [W:0] MAXV_D = (W+1)'(MAXV);

	logic en;
	logic v_s1;
	ia_pkg::ctl_t ctl_s1;
	logic signed [W-1:0] a_lo_s1, a_hi_s1, mb_lo_s1, mb_hi_s1;
	logic signed [W-1:0] db_lo_s1, db_hi_s1, s_lo_s1, s_hi_s1;

	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	ia_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(req.valid),
		.kind(req.kind), .a_lo(req.a_lo), .a_hi(req.a_hi),
		.b_lo(req.b_lo), .b_hi(req.b_hi),
		.cond_code(req.cond_code), .const_value(req.const_value),
		.v_s1(v_s1), .ctl_s1(ctl_s1),
		.a_lo_s1(a_lo_s1), .a_hi_s1(a_hi_s1),
		.mb_lo_s1(mb_lo_s1), .mb_hi_s1(mb_hi_s1),
		.db_lo_s1(db_lo_s1), .db_hi_s1(db_hi_s1),
		.s_lo_s1(s_lo_s1), .s_hi_s1(s_hi_s1)
	);

	logic signed [W:0] quo [0:3];

	ia_div_pipe #(.W(W)) u_div0 (.clk(clk), .en(en), .num(a_lo_s1), .den(db_lo_s1), .quo(quo[0]));
	ia_div_pipe #(.W(W)) u_div1 (.clk(clk), .en(en), .num(a_lo_s1), .den(db_hi_s1), .quo(quo[1]));
	ia_div_pipe #(.W(W)) u_div2 (.clk(clk), .en(en), .num(a_hi_s1), .den(db_lo_s1), .quo(quo[2]));
	ia_div_pipe #(.W(W)) u_div3 (.clk(clk), .en(en), .num(a_hi_s1), .den(db_hi_s1), .quo(quo[3]));

	// delay line alongside the dividers
	logic                v_q    [1:DIV_LAT];
	ia_pkg::ctl_t        ctl_q  [1:DIV_LAT];
	logic signed [W-1:0] alo_q  [1:DIV_LAT];
	logic signed [W-1:0] ahi_q  [1:DIV_LAT];
	logic signed [W-1:0] mblo_q [1:DIV_LAT];
	logic signed [W-1:0] mbhi_q [1:DIV_LAT];
	logic signed [W-1:0] slo_q  [1:DIV_LAT];
	logic signed [W-1:0] shi_q  [1:DIV_LAT];

	for (genvar j = 1; j <= DIV_LAT; j++) begin : g_dly
		if (j == 1) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[j] <= 1'b0;
				end else if (en) begin
					v_q[j] <= v_s1;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					ctl_q[j]  <= ctl_s1;
					alo_q[j]  <= a_lo_s1;
					ahi_q[j]  <= a_hi_s1;
					mblo_q[j] <= mb_lo_s1;
					mbhi_q[j] <= mb_hi_s1;
					slo_q[j]  <= s_lo_s1;
					shi_q[j]  <= s_hi_s1;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[j] <= 1'b0;
				end else if (en) begin
					v_q[j] <= v_q[j-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					ctl_q[j]  <= ctl_q[j-1];
					alo_q[j]  <= alo_q[j-1];
					ahi_q[j]  <= ahi_q[j-1];
					mblo_q[j] <= mblo_q[j-1];
					mbhi_q[j] <= mbhi_q[j-1];
					slo_q[j]  <= slo_q[j-1];
					shi_q[j]  <= shi_q[j-1];
				end
			end
		end
	end

	// products, aligned with the quotients
	logic signed [2*W-1:0] prod_s2 [0:3];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2[0] <= (2*W)'(alo_q[DIV_LAT-1]) * (2*W)'(mblo_q[DIV_LAT-1]);
			prod_s2[1] <= (2*W)'(alo_q[DIV_LAT-1]) * (2*W)'(mbhi_q[DIV_LAT-1]);
			prod_s2[2] <= (2*W)'(ahi_q[DIV_LAT-1]) * (2*W)'(mblo_q[DIV_LAT-1]);
			prod_s2[3] <= (2*W)'(ahi_q[DIV_LAT-1]) * (2*W)'(mbhi_q[DIV_LAT-1]);
		end
	end

	// first min/max level
	logic signed [W:0] cand [0:7];
	logic signed [2*W-1:0] pmin_s3 [0:1];
	logic signed [2*W-1:0] pmax_s3 [0:1];
	logic signed [W:0] dmin_s3 [0:3];
	logic signed [W:0] dmax_s3 [0:3];
	logic v_s3;
	ia_pkg::ctl_t ctl_s3;
	logic signed [W-1:0] slo_s3, shi_s3;

	always_comb begin
		cand[0] = quo[0];
		cand[1] = quo[1];
		cand[2] = quo[2];
		cand[3] = quo[3];
		if (ctl_q[DIV_LAT].strad) begin
			cand[4] = -(W+1)'(alo_q[DIV_LAT]);
			cand[5] = -(W+1)'(ahi_q[DIV_LAT]);
			cand[6] = (W+1)'(alo_q[DIV_LAT]);
			cand[7] = (W+1)'(ahi_q[DIV_LAT]);
		end else begin
			cand[4] = quo[0];
			cand[5] = quo[0];
			cand[6] = quo[0];
			cand[7] = quo[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_q[DIV_LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				pmin_s3[i] <= (prod_s2[2*i] < prod_s2[2*i+1]) ? prod_s2[2*i] : prod_s2[2*i+1];
				pmax_s3[i] <= (prod_s2[2*i] > prod_s2[2*i+1]) ? prod_s2[2*i] : prod_s2[2*i+1];
			end
			for (int i = 0; i < 4; i++) begin
				dmin_s3[i] <= (cand[2*i] < cand[2*i+1]) ? cand[2*i] : cand[2*i+1];
				dmax_s3[i] <= (cand[2*i] > cand[2*i+1]) ? cand[2*i] : cand[2*i+1];
			end
			ctl_s3 <= ctl_q[DIV_LAT];
			slo_s3 <= slo_q[DIV_LAT];
			shi_s3 <= shi_q[DIV_LAT];
		end
	end

	// final reduce, range rule and result select
	logic signed [2*W-1:0] pmn, pmx;
	logic signed [W:0] dmn01, dmn23, dmx01, dmx23, dmn, dmx;
	logic signed [W-1:0] r_lo, r_hi;
	logic r_ok;

	always_comb begin
		pmn = (pmin_s3[0] < pmin_s3[1]) ? pmin_s3[0] : pmin_s3[1];
		pmx = (pmax_s3[0] > pmax_s3[1]) ? pmax_s3[0] : pmax_s3[1];
		dmn01 = (dmin_s3[0] < dmin_s3[1]) ? dmin_s3[0] : dmin_s3[1];
		dmn23 = (dmin_s3[2] < dmin_s3[3]) ? dmin_s3[2] : dmin_s3[3];
		dmx01 = (dmax_s3[0] > dmax_s3[1]) ? dmax_s3[0] : dmax_s3[1];
		dmx23 = (dmax_s3[2] > dmax_s3[3]) ? dmax_s3[2] : dmax_s3[3];
		dmn = (dmn01 < dmn23) ? dmn01 : dmn23;
		dmx = (dmx01 > dmx23) ? dmx01 : dmx23;

		r_ok = 1'b0;
		r_lo = W'(MAXV);
		r_hi = W'(MINV);
		unique case (ctl_s3.kind)
			ia_pkg::KIND_MUL: begin
				if (ctl_s3.ab_ok) begin
					r_ok = 1'b1;
					if (pmn < MINV_P || pmx > MAXV_P) begin
						r_lo = W'(MINV);
						r_hi = W'(MAXV);
					end else begin
						r_lo = W'(pmn);
						r_hi = W'(pmx);
					end
				end
			end
			ia_pkg::KIND_DIV: begin
				if (ctl_s3.ab_ok) begin
					r_ok = 1'b1;
					if (ctl_s3.bz || dmn < MINV_D || dmx > MAXV_D) begin
						r_lo = W'(MINV);
						r_hi = W'(MAXV);
					end else begin
						r_lo = W'(dmn);
						r_hi = W'(dmx);
					end
				end
			end
			ia_pkg::KIND_ADD, ia_pkg::KIND_MERGE,
			ia_pkg::KIND_NARROW_T, ia_pkg::KIND_NARROW_F: begin
				if (ctl_s3.s_ok) begin
					r_ok = 1'b1;
					r_lo = slo_s3;
					r_hi = shi_s3;
				end
			end
			default: r_ok = 1'b0;
		endcase
	end

	logic vo_q;
	logic signed [W-1:0] lo_q, hi_q;
	logic ok_q, at_q, af_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_q <= r_lo;
			hi_q <= r_hi;
			ok_q <= r_ok;
			at_q <= ctl_s3.at;
			af_q <= ctl_s3.af;
		end
	end

	assign rsp.valid        = vo_q;
	assign rsp.res_lo       = 32'(lo_q);
	assign rsp.res_hi       = 32'(hi_q);
	assign rsp.res_valid    = ok_q;
	assign rsp.always_true  = at_q;
	assign rsp.always_false = af_q;

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q && ok_q |-> lo_q <= hi_q)
		else $error("valid result with lo above hi");
	a_canon: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q && !ok_q |-> lo_q == W'(MAXV) && hi_q == W'(MINV))
		else $error("invalid result not canonical");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> !(at_q && af_q) && !(at_q && !ok_q) && !(af_q && ok_q))
		else $error("flags inconsistent with result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s3) && $stable(vo_q))
		else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

// ===== design/ia_front.sv =====
// Input stage: operand clamping, add, merge, narrowing and divisor adjust.
`default_nettype none
module ia_front #(
	parameter int W = ia_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_v,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] a_lo,
	input  wire logic signed [31:0] a_hi,
	input  wire logic signed [31:0] b_lo,
	input  wire logic signed [31:0] b_hi,
	input  wire logic [2:0]         cond_code,
	input  wire logic signed [31:0] const_value,
	output logic                    v_s1,
	output ia_pkg::ctl_t            ctl_s1,
	output logic signed [W-1:0]     a_lo_s1,
	output logic signed [W-1:0]     a_hi_s1,
	output logic signed [W-1:0]     mb_lo_s1,
	output logic signed [W-1:0]     mb_hi_s1,
	output logic signed [W-1:0]     db_lo_s1,
	output logic signed [W-1:0]     db_hi_s1,
	output logic signed [W-1:0]     s_lo_s1,
	output logic signed [W-1:0]     s_hi_s1
);
	localparam logic signed [ia_pkg::WIDE-1:0] MINV = ia_pkg::minv(W);
	localparam logic signed [ia_pkg::WIDE-1:0] MAXV = ia_pkg::maxv(W);
	localparam logic signed [ia_pkg::WIDE-1:0] ONE = ia_pkg::WIDE'(1);

	ia_pkg::kind_t kd;
	ia_pkg::cc_t   cc;
	ia_pkg::nv_t   a, b, nt, nf, s, inv;
	logic signed [ia_pkg::WIDE-1:0] k, km1, kp1, sum_lo, sum_hi, dbl, dbh;
	logic flag, holds, at, af, bz;

	always_comb begin
		kd = ia_pkg::kind_t'(kind);
		cc = ia_pkg::cc_t'(cond_code);
		k = ia_pkg::WIDE'(const_value);
		km1 = k - ONE;
		kp1 = k + ONE;

		inv.ok = 1'b0;
		inv.lo = MAXV;
		inv.hi = MINV;

		a.ok = a_lo <= a_hi;
		a.lo = ia_pkg::WIDE'(a_lo);
		a.hi = ia_pkg::WIDE'(a_hi);
		if (a.lo < MINV || a.hi > MAXV) begin
			a.lo = MINV;
			a.hi = MAXV;
		end
		b.ok = b_lo <= b_hi;
		b.lo = ia_pkg::WIDE'(b_lo);
		b.hi = ia_pkg::WIDE'(b_hi);
		if (b.lo < MINV || b.hi > MAXV) begin
			b.lo = MINV;
			b.hi = MAXV;
		end

		holds = a.ok && a.lo <= k && k <= a.hi;

		flag = 1'b1;
		nt = a;
		unique case (cc)
			ia_pkg::CC_EQ: nt = ia_pkg::drop_high(ia_pkg::raise_low(a, k), k);
			ia_pkg::CC_NE: flag = !holds;
			ia_pkg::CC_LT: nt = ia_pkg::drop_high(a, km1);
			ia_pkg::CC_LE: nt = ia_pkg::drop_high(a, k);
			ia_pkg::CC_GT: nt = ia_pkg::raise_low(a, kp1);
			ia_pkg::CC_GE: nt = ia_pkg::raise_low(a, k);
			default: flag = 1'b0;
		endcase
		af = flag && !nt.ok;
		at = flag && nt.ok && nt.lo == a.lo && nt.hi == a.hi;

		nf = a;
		unique case (cc)
			ia_pkg::CC_NE: nf = holds ? a : inv;
			ia_pkg::CC_LT: nf = ia_pkg::raise_low(a, k);
			ia_pkg::CC_LE: nf = ia_pkg::raise_low(a, kp1);
			ia_pkg::CC_GT: nf = ia_pkg::drop_high(a, k);
			ia_pkg::CC_GE: nf = ia_pkg::drop_high(a, km1);
			default: nf = a;
		endcase

		sum_lo = a.lo + b.lo;
		sum_hi = a.hi + b.hi;

		s = inv;
		unique case (kd)
			ia_pkg::KIND_ADD: begin
				if (a.ok && b.ok) begin
					s.ok = 1'b1;
					s.lo = (sum_lo < MINV || sum_hi > MAXV) ? MINV : sum_lo;
					s.hi = (sum_lo < MINV || sum_hi > MAXV) ? MAXV : sum_hi;
				end
			end
			ia_pkg::KIND_MERGE: begin
				if (a.ok && b.ok) begin
					s.ok = 1'b1;
					s.lo = (a.lo < b.lo) ? a.lo : b.lo;
					s.hi = (a.hi > b.hi) ? a.hi : b.hi;
				end else if (a.ok) begin
					s = a;
				end else if (b.ok) begin
					s = b;
				end
			end
			ia_pkg::KIND_NARROW_T: s = nt;
			ia_pkg::KIND_NARROW_F: s = nf;
			ia_pkg::KIND_MUL, ia_pkg::KIND_DIV: s = inv;
			default: s = inv;
		endcase

		bz = b.lo == '0 && b.hi == '0;
		dbl = (b.lo == '0) ? ONE : b.lo;
		dbh = (b.lo != '0 && b.hi == '0) ? -ONE : b.hi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.kind  <= kd;
			ctl_s1.ab_ok <= a.ok && b.ok;
			ctl_s1.bz    <= bz;
			ctl_s1.strad <= dbl < 0 && dbh > 0;
			ctl_s1.s_ok  <= s.ok;
			ctl_s1.at    <= (kd == ia_pkg::KIND_NARROW_T) && at;
			ctl_s1.af    <= (kd == ia_pkg::KIND_NARROW_T) && af;
			a_lo_s1  <= W'(a.lo);
			a_hi_s1  <= W'(a.hi);
			mb_lo_s1 <= W'(b.lo);
			mb_hi_s1 <= W'(b.hi);
			db_lo_s1 <= W'(dbl);
			db_hi_s1 <= W'(dbh);
			s_lo_s1  <= W'(s.lo);
			s_hi_s1  <= W'(s.hi);
		end
	end
endmodule
`default_nettype wire

// ===== design/ia_div_pipe.sv =====
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
`default_nettype none
module ia_div_pipe #(
	parameter int W = ia_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic signed [W-1:0] num,
	input  wire logic signed [W-1:0] den,
	output logic signed [W:0]      quo
);
	logic [W-1:0] nm_q [0:W];
	logic [W-1:0] dm_q [0:W];
	logic [W-1:0] rm_q [0:W];
	logic         ng_q [0:W];
	logic signed [W:0] quo_q;

	always_ff @(posedge clk) begin
		if (en) begin
			nm_q[0] <= num[W-1] ? W'(-num) : W'(num);
			dm_q[0] <= den[W-1] ? W'(-den) : W'(den);
			rm_q[0] <= '0;
			ng_q[0] <= num[W-1] ^ den[W-1];
		end
	end

	for (genvar i = 0; i < W; i++) begin : g_step
		logic [W:0] trial, diff;
		logic       ge;
		always_comb begin
			trial = {rm_q[i], nm_q[i][W-1]};
			diff  = trial - {1'b0, dm_q[i]};
			ge    = trial >= {1'b0, dm_q[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rm_q[i+1] <= ge ? diff[W-1:0] : trial[W-1:0];
				nm_q[i+1] <= {nm_q[i][W-2:0], ge};
				dm_q[i+1] <= dm_q[i];
				ng_q[i+1] <= ng_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= ng_q[W] ? -$signed({1'b0, nm_q[W]}) : $signed({1'b0, nm_q[W]});
		end
	end

	assign quo = quo_q;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the signed integer interval unit.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;
	localparam int N_RANDOM = 950;

	typedef struct {
		longint lo;
		longint hi;
		bit     ok;
	} span_t;

	typedef struct {
		logic [2:0]         kind;
		logic signed [31:0] a_lo, a_hi, b_lo, b_hi;
		logic [2:0]         cond_code;
		logic signed [31:0] const_value;
	} op_t;

	typedef struct {
		logic signed [31:0] lo, hi;
		logic               ok, at, af;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;

	ia_req_if req();
	ia_rsp_if rsp();

	int_interval_alu dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	op_t  pending_ops[$];
	res_t expected_results[$];
	int   errors = 0;
	int   sent = 0;
	bit   req_taken = 0;

	function automatic span_t bad_span();
		span_t r;
		r.lo = MAXV; r.hi = MINV; r.ok = 0;
		return r;
	endfunction

	function automatic span_t full_span();
		span_t r;
		r.lo = MINV; r.hi = MAXV; r.ok = 1;
		return r;
	endfunction

	function automatic span_t make_span(longint lo, longint hi);
		span_t r;
		if (lo < MINV || hi > MAXV) return full_span();
		if (hi < lo) return bad_span();
		r.lo = lo; r.hi = hi; r.ok = 1;
		return r;
	endfunction

	function automatic span_t lift_low(span_t r, longint v);
		if (!r.ok || r.hi < v) return bad_span();
		return make_span(v > r.lo ? v : r.lo, r.hi);
	endfunction

	function automatic span_t cap_high(span_t r, longint v);
		if (!r.ok || r.lo > v) return bad_span();
		return make_span(r.lo, v < r.hi ? v : r.hi);
	endfunction

	function automatic span_t hull4(longint c[8], int n);
		longint mn, mx;
		mn = c[0]; mx = c[0];
		for (int i = 1; i < n; i++) begin
			if (c[i] < mn) mn = c[i];
			if (c[i] > mx) mx = c[i];
		end
		return make_span(mn, mx);
	endfunction

	function automatic res_t interval_result(op_t op);
		span_t  a, b, r;
		longint k, c[8];
		bit     at, af, flag;
		res_t   o;
		a = (op.a_lo > op.a_hi) ? bad_span() : make_span(op.a_lo, op.a_hi);
		b = (op.b_lo > op.b_hi) ? bad_span() : make_span(op.b_lo, op.b_hi);
		k = op.const_value;
		r = bad_span();
		at = 0; af = 0;
		case (op.kind)
			ia_pkg::KIND_ADD: if (a.ok && b.ok) r = make_span(a.lo + b.lo, a.hi + b.hi);
			ia_pkg::KIND_MUL: if (a.ok && b.ok) begin
				c[0] = a.lo * b.lo; c[1] = a.lo * b.hi;
				c[2] = a.hi * b.lo; c[3] = a.hi * b.hi;
				r = hull4(c, 4);
			end
			ia_pkg::KIND_DIV: if (a.ok && b.ok) begin
				if (b.lo == 0 && b.hi == 0) r = full_span();
				else begin
					if (b.lo == 0) b.lo = 1;
					else if (b.hi == 0) b.hi = -1;
					c[0] = a.lo / b.lo; c[1] = a.lo / b.hi;
					c[2] = a.hi / b.lo; c[3] = a.hi / b.hi;
					if (b.lo < 0 && b.hi > 0) begin
						c[4] = -a.lo; c[5] = -a.hi; c[6] = a.lo; c[7] = a.hi;
						r = hull4(c, 8);
					end else r = hull4(c, 4);
				end
			end
			ia_pkg::KIND_MERGE: begin
				if (a.ok && b.ok)
					r = make_span(a.lo < b.lo ? a.lo : b.lo, a.hi > b.hi ? a.hi : b.hi);
				else if (a.ok) r = a;
				else if (b.ok) r = b;
			end
			ia_pkg::KIND_NARROW_T: begin
				flag = 1;
				r = a;
				case (op.cond_code)
					ia_pkg::CC_EQ: r = cap_high(lift_low(a, k), k);
					ia_pkg::CC_NE: if (a.ok && a.lo <= k && k <= a.hi) flag = 0;
					ia_pkg::CC_LT: r = cap_high(a, k - 1);
					ia_pkg::CC_LE: r = cap_high(a, k);
					ia_pkg::CC_GT: r = lift_low(a, k + 1);
					ia_pkg::CC_GE: r = lift_low(a, k);
					default: flag = 0;
				endcase
				if (flag) begin
					if (!r.ok) af = 1;
					else if (r.lo == a.lo && r.hi == a.hi) at = 1;
				end
			end
			ia_pkg::KIND_NARROW_F: begin
				r = a;
				case (op.cond_code)
					ia_pkg::CC_NE: if (!(a.ok && a.lo <= k && k <= a.hi)) r = bad_span();
					ia_pkg::CC_LT: r = lift_low(a, k);
					ia_pkg::CC_LE: r = lift_low(a, k + 1);
					ia_pkg::CC_GT: r = cap_high(a, k);
					ia_pkg::CC_GE: r = cap_high(a, k - 1);
					default: ;
				endcase
			end
			default: ;
		endcase
		if (!r.ok) r = bad_span();
		o.lo = r.lo[31:0]; o.hi = r.hi[31:0];
		o.ok = r.ok; o.at = at; o.af = af;
		return o;
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 6))
			0: return $signed($urandom_range(0, 40)) - 20;
			1: return 32'sh80000000 + $urandom_range(0, 3);
			2: return 32'sh7fffffff - $urandom_range(0, 3);
			3: return $signed($urandom_range(0, 2000)) - 1000;
			4: return $signed($urandom_range(0, 131072)) - 65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_op(logic [2:0] kind, logic signed [31:0] al, ah, bl, bh,
			logic [2:0] cc, logic signed [31:0] kv);
		op_t op;
		op.kind = kind; op.a_lo = al; op.a_hi = ah; op.b_lo = bl; op.b_hi = bh;
		op.cond_code = cc; op.const_value = kv;
		pending_ops.push_back(op);
	endtask

	task automatic report(string what, logic signed [31:0] got, want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic int phase();
		return sent < N_RANDOM / 3 ? 0 : (sent < 2 * N_RANDOM / 3 ? 1 : 2);
	endfunction

	// request driver
	always @(negedge clk) begin
		int idle;
		idle = phase() == 0 ? 9 : (phase() == 1 ? 87 : 0);
		if (arst_n && (!req.valid || req_taken)) begin
			if (pending_ops.size() > 0 && $urandom_range(0, 99) >= idle) begin
				op_t op;
				op = pending_ops.pop_front();
				req.valid <= 1;
				req.kind <= op.kind;
				req.a_lo <= op.a_lo; req.a_hi <= op.a_hi;
				req.b_lo <= op.b_lo; req.b_hi <= op.b_hi;
				req.cond_code <= op.cond_code;
				req.const_value <= op.const_value;
				sent++;
			end else
				req.valid <= 0;
		end
	end

	// response back-pressure
	always @(negedge clk) begin
		int stall;
		stall = phase() == 0 ? 87 : (phase() == 1 ? 9 : 0);
		rsp.ready <= arst_n && $urandom_range(0, 99) >= stall;
	end

	// accept and check
	always @(posedge clk) begin
		op_t  op;
		res_t want;
		req_taken <= req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			op.kind = req.kind;
			op.a_lo = req.a_lo; op.a_hi = req.a_hi;
			op.b_lo = req.b_lo; op.b_hi = req.b_hi;
			op.cond_code = req.cond_code; op.const_value = req.const_value;
			expected_results.push_back(interval_result(op));
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("unexpected result item at %0t", $realtime);
			end else begin
				want = expected_results.pop_front();
				if (rsp.res_lo !== want.lo) report("res_lo", rsp.res_lo, want.lo);
				if (rsp.res_hi !== want.hi) report("res_hi", rsp.res_hi, want.hi);
				if (rsp.res_valid !== want.ok) report("res_valid", rsp.res_valid, want.ok);
				if (rsp.always_true !== want.at) report("always_true", rsp.always_true, want.at);
				if (rsp.always_false !== want.af)
					report("always_false", rsp.always_false, want.af);
			end
		end
	end

	initial begin
		logic signed [31:0] x, y, z, w;
		req.valid = 0; req.kind = ia_pkg::KIND_ADD;
		req.a_lo = 0; req.a_hi = 0; req.b_lo = 0; req.b_hi = 0;
		req.cond_code = ia_pkg::CC_EQ; req.const_value = 0;
		rsp.ready = 0;

		// directed: edges, overflow, invalid operands, division corners
		queue_op(ia_pkg::KIND_ADD, 32'sh7fffffff, 32'sh7fffffff, 1, 1, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_ADD, -5, 5, 10, 20, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_ADD, 5, 1, 0, 0, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_MUL, 32'sh80000000, 3, -1, 2, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_MUL, -3, 4, -7, 2, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_DIV, 10, 100, 0, 0, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_DIV, 10, 100, 0, 7, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_DIV, -100, 10, -3, 0, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_DIV, -100, 37, -3, 5, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_DIV, 32'sh80000000, 0, -1, -1, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_DIV, 1, 2, 3, 1, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_MERGE, 1, 3, 10, 20, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_MERGE, 3, 1, 10, 20, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_MERGE, 1, 3, 20, 10, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_MERGE, 3, 1, 20, 10, ia_pkg::CC_EQ, 0);
		queue_op(ia_pkg::KIND_NARROW_T, 0, 10, 0, 0, ia_pkg::CC_NE, 5);
		queue_op(ia_pkg::KIND_NARROW_T, 0, 10, 0, 0, ia_pkg::CC_NE, 50);
		queue_op(ia_pkg::KIND_NARROW_T, 0, 32'sh7fffffff, 0, 0, ia_pkg::CC_GT, 32'sh7fffffff);
		queue_op(ia_pkg::KIND_NARROW_T, 32'sh80000000, 0, 0, 0, ia_pkg::CC_LT, 32'sh80000000);
		queue_op(ia_pkg::KIND_NARROW_T, 0, 10, 0, 0, ia_pkg::CC_EQ, 4);
		queue_op(ia_pkg::KIND_NARROW_T, 0, 10, 0, 0, ia_pkg::CC_LE, 20);
		queue_op(ia_pkg::KIND_NARROW_T, 10, 0, 0, 0, ia_pkg::CC_GE, 3);
		queue_op(ia_pkg::KIND_NARROW_T, 0, 10, 0, 0, 3'd6, 3);
		queue_op(ia_pkg::KIND_NARROW_F, 0, 10, 0, 0, ia_pkg::CC_NE, 3);
		queue_op(ia_pkg::KIND_NARROW_F, 0, 10, 0, 0, 3'd7, 3);
		queue_op(3'd6, 0, 10, 0, 1, ia_pkg::CC_EQ, 0);
		queue_op(3'd7, 0, 10, 0, 1, ia_pkg::CC_EQ, 0);

		for (int i = 0; i < N_RANDOM; i++) begin
			x = pick_value(); y = pick_value(); z = pick_value(); w = pick_value();
			// mostly well-formed intervals, some reversed ones
			if ($urandom_range(0, 9) != 0 && x > y) begin x ^= y; y ^= x; x ^= y; end
			if ($urandom_range(0, 9) != 0 && z > w) begin z ^= w; w ^= z; z ^= w; end
			if ($urandom_range(0, 9) == 0) begin z = 0; w = $urandom_range(0, 1) ? 0 : w; end
			queue_op(3'($urandom_range(0, 19) == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5)),
				x, y, z, w, 3'($urandom_range(0, 7)),
				$urandom_range(0, 1) ? 32'(x + $signed($urandom_range(0, 6)) - 3) : pick_value());
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (pending_ops.size() == 0);
		wait (expected_results.size() == 0 && !req.valid);
		repeat (60) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
design/ia_pkg.sv
design/ia_req_if.sv
design/ia_rsp_if.sv
design/ia_front.sv
design/ia_div_pipe.sv
design/int_interval_alu.sv
tb/testbench.sv
